// ===== design/ipv4hc_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv4 header checker package
// Shared types and constants for the byte-serial IPv4 header checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4hc_pkg;

    // Header length in bytes; the byte counter parks here when idle.
    localparam logic [4:0] HDR_BYTES     = 5'd20;

    // Byte positions inside the fixed IPv4 header.
    localparam logic [4:0] POS_VER_IHL   = 5'd0;
    localparam logic [4:0] POS_LEN_LO    = 5'd3;
    localparam logic [4:0] POS_FRAG_LO   = 5'd7;
    localparam logic [4:0] POS_PROTO     = 5'd9;
    localparam logic [4:0] POS_CKSUM_LO  = 5'd11;
    localparam logic [4:0] POS_SRC_FIRST = 5'd12;
    localparam logic [4:0] POS_SRC_LAST  = 5'd15;
    localparam logic [4:0] POS_DST_FIRST = 5'd16;
    localparam logic [4:0] POS_LAST      = 5'd19;

    localparam logic [7:0]  VERSION_MASK = 8'hF0;
    localparam logic [7:0]  VERSION_IPV4 = 8'h40;
    localparam logic [7:0]  IHL_MASK     = 8'h0F;
    localparam logic [7:0]  IHL_NO_OPTS  = 8'h05;
    localparam logic [15:0] FRAG_MASK    = 16'h1FFF;
    localparam logic [15:0] PLEN_BIAS    = 16'd20;

    localparam logic [7:0]  PROTO_ICMP   = 8'd1;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;

    typedef enum logic [2:0] {
        VERDICT_ICMP        = 3'd0,
        VERDICT_UDP         = 3'd1,
        VERDICT_PROTO_UNRCH = 3'd2,
        VERDICT_BAD_VERSION = 3'd3,
        VERDICT_OPTIONS     = 3'd4,
        VERDICT_FRAGMENT    = 3'd5,
        VERDICT_BAD_CKSUM   = 3'd6,
        VERDICT_NOT_OURS    = 3'd7
    } verdict_t;

    // Everything captured from one header, as it stands after its last byte.
    typedef struct packed {
        logic [7:0]  ver_ihl;
        logic [15:0] total_length;
        logic        frag_nonzero;
        logic [15:0] rcv_cksum;
        logic [19:0] sum;
        logic [31:0] source;
        logic        dst_mismatch;
        logic [7:0]  protocol;
    } hdr_fields_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [15:0] payload_length;
        logic [31:0] source_address;
        logic [7:0]  protocol_number;
    } result_t;

endpackage

`default_nettype wire

// ===== design/ipv4hc_parser.sv =====
// ----------------------------------------------------------------------------
// IPv4 header byte parser
// Tracks the byte position, accumulates the header word sum and captures the
// header fields one byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hc_parser (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_we,
    input  wire logic [31:0]             cfg_wdata,
    input  wire logic                    byte_valid,
    input  wire logic [7:0]              header_byte,
    input  wire logic                    start_of_header,
    output      logic                    hdr_done,
    output      ipv4hc_pkg::hdr_fields_t hdr_fields
);

    logic [31:0] my_address_reg;
    logic [4:0]  pos_reg, pos_next;
    logic [19:0] sum_reg, sum_next;
    logic [7:0]  high_reg, high_next;
    logic [7:0]  ver_ihl_reg, ver_ihl_next;
    logic [15:0] total_len_reg, total_len_next;
    logic        frag_reg, frag_next;
    logic [15:0] cksum_reg, cksum_next;
    logic [31:0] src_reg, src_next;
    logic        mismatch_reg, mismatch_next;
    logic [7:0]  proto_reg, proto_next;

    logic [4:0]  pos_eff;
    logic        active;
    logic [15:0] word;
    logic [7:0]  want;

    always_comb begin
        // A start marker restarts the header regardless of where we were.
        pos_eff = start_of_header ? 5'd0 : pos_reg;
        active  = byte_valid && (pos_eff < ipv4hc_pkg::HDR_BYTES);
        word    = {high_reg, header_byte};

        case (pos_eff[1:0])
            2'd0:    want = my_address_reg[31:24];
            2'd1:    want = my_address_reg[23:16];
            2'd2:    want = my_address_reg[15:8];
            default: want = my_address_reg[7:0];
        endcase

        pos_next       = pos_reg;
        sum_next       = sum_reg;
        high_next      = high_reg;
        ver_ihl_next   = ver_ihl_reg;
        total_len_next = total_len_reg;
        frag_next      = frag_reg;
        cksum_next     = cksum_reg;
        src_next       = src_reg;
        mismatch_next  = mismatch_reg;
        proto_next     = proto_reg;

        if (byte_valid && start_of_header) begin
            sum_next      = '0;
            frag_next     = 1'b0;
            src_next      = '0;
            mismatch_next = 1'b0;
        end

        if (active) begin
            if (!pos_eff[0]) begin
                high_next = header_byte;
            end else begin
                if (pos_eff == ipv4hc_pkg::POS_CKSUM_LO) begin
                    cksum_next = word;
                end else begin
                    sum_next = sum_next + {4'd0, word};
                end
                if (pos_eff == ipv4hc_pkg::POS_LEN_LO) begin
                    total_len_next = word;
                end
                if (pos_eff == ipv4hc_pkg::POS_FRAG_LO) begin
                    frag_next = (word & ipv4hc_pkg::FRAG_MASK) != 16'd0;
                end
            end
            if (pos_eff == ipv4hc_pkg::POS_VER_IHL) begin
                ver_ihl_next = header_byte;
            end
            if (pos_eff == ipv4hc_pkg::POS_PROTO) begin
                proto_next = header_byte;
            end
            if (pos_eff >= ipv4hc_pkg::POS_SRC_FIRST && pos_eff <= ipv4hc_pkg::POS_SRC_LAST) begin
                src_next = {src_next[23:0], header_byte};
            end
            if (pos_eff >= ipv4hc_pkg::POS_DST_FIRST && want != header_byte) begin
                mismatch_next = 1'b1;
            end
            pos_next = pos_eff + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            my_address_reg <= '0;
            pos_reg        <= ipv4hc_pkg::HDR_BYTES;
            sum_reg        <= '0;
            frag_reg       <= 1'b0;
            src_reg        <= '0;
            mismatch_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                my_address_reg <= cfg_wdata;
            end
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            frag_reg     <= frag_next;
            src_reg      <= src_next;
            mismatch_reg <= mismatch_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_reg      <= '0;
            ver_ihl_reg   <= '0;
            total_len_reg <= '0;
            cksum_reg     <= '0;
            proto_reg     <= '0;
        end else begin
            high_reg      <= high_next;
            ver_ihl_reg   <= ver_ihl_next;
            total_len_reg <= total_len_next;
            cksum_reg     <= cksum_next;
            proto_reg     <= proto_next;
        end
    end

    assign hdr_done = active && (pos_eff == ipv4hc_pkg::POS_LAST);

    always_comb begin
        hdr_fields.ver_ihl      = ver_ihl_next;
        hdr_fields.total_length = total_len_next;
        hdr_fields.frag_nonzero = frag_next;
        hdr_fields.rcv_cksum    = cksum_next;
        hdr_fields.sum          = sum_next;
        hdr_fields.source       = src_next;
        hdr_fields.dst_mismatch = mismatch_next;
        hdr_fields.protocol     = proto_next;
    end

endmodule

`default_nettype wire

// ===== design/ipv4hc_classify.sv =====
// ----------------------------------------------------------------------------
// IPv4 header classifier
// Folds the header checksum and applies the drop checks in priority order.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hc_classify (
    input  wire ipv4hc_pkg::hdr_fields_t hdr_fields,
    output      ipv4hc_pkg::result_t     result
);

    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] calc_cksum;

    always_comb begin
        // Two folds are enough: nine words never carry past bit 19.
        fold1      = {1'b0, hdr_fields.sum[15:0]} + {13'd0, hdr_fields.sum[19:16]};
        fold2      = fold1[15:0] + {15'd0, fold1[16]};
        calc_cksum = ~fold2;

        result.payload_length  = '0;
        result.source_address  = '0;
        result.protocol_number = hdr_fields.protocol;

        if ((hdr_fields.ver_ihl & ipv4hc_pkg::VERSION_MASK) != ipv4hc_pkg::VERSION_IPV4) begin
            result.verdict = ipv4hc_pkg::VERDICT_BAD_VERSION;
        end else if ((hdr_fields.ver_ihl & ipv4hc_pkg::IHL_MASK) != ipv4hc_pkg::IHL_NO_OPTS) begin
            result.verdict = ipv4hc_pkg::VERDICT_OPTIONS;
        end else if (hdr_fields.frag_nonzero) begin
            result.verdict = ipv4hc_pkg::VERDICT_FRAGMENT;
        end else if (calc_cksum != hdr_fields.rcv_cksum) begin
            result.verdict = ipv4hc_pkg::VERDICT_BAD_CKSUM;
        end else if (hdr_fields.dst_mismatch) begin
            result.verdict = ipv4hc_pkg::VERDICT_NOT_OURS;
        end else begin
            if (hdr_fields.protocol == ipv4hc_pkg::PROTO_ICMP) begin
                result.verdict = ipv4hc_pkg::VERDICT_ICMP;
            end else if (hdr_fields.protocol == ipv4hc_pkg::PROTO_UDP) begin
                result.verdict = ipv4hc_pkg::VERDICT_UDP;
            end else begin
                result.verdict = ipv4hc_pkg::VERDICT_PROTO_UNRCH;
            end
            result.payload_length = hdr_fields.total_length - ipv4hc_pkg::PLEN_BIAS;
            result.source_address = hdr_fields.source;
        end
    end

endmodule

`default_nettype wire

// ===== design/ipv4hc_out_buf.sv =====
// ----------------------------------------------------------------------------
// IPv4 header checker result buffer
// Output register plus one skid entry so the input side keeps moving while a
// result waits for the downstream to take it.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hc_out_buf (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire ipv4hc_pkg::result_t push_data,
    output      logic                push_ready,
    output      logic                out_valid,
    input  wire logic                out_ready,
    output      ipv4hc_pkg::result_t out_data
);

    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    ipv4hc_pkg::result_t out_data_reg, out_data_next;
    ipv4hc_pkg::result_t skid_data_reg, skid_data_next;
    logic                pop;

    assign pop        = out_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (skid_valid_reg) begin
            // No push can arrive here because push_ready is low.
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

// ===== design/ipv4_header_checker.sv =====
// ----------------------------------------------------------------------------
// IPv4 header checker
// Byte-serial IPv4 header validation with one verdict per twenty-byte header.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Width  Contents
// s_*       in   8+1    tdata: header_byte[7:0]; tuser: start_of_header[0]
// m_*       out  56+3   tdata: payload_length, source_address, protocol_number;
//                       tuser: verdict[2:0]
// cfg_*     in   32     this host's address
//
// One header byte is taken per cycle while s_tready is high; a header takes twenty
// transfers, and on its last byte its result is registered in the output or skid entry.
// Reset (synchronous, aresetn low) parks the byte counter idle, clears the
// address to zero and empties the result buffer.
// While m_tready is low the input keeps flowing until the one skid entry is
// holding a second result; then s_tready drops until a result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_header_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] header_byte
    input  wire logic [0:0]  s_tuser,   // [0] start_of_header
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [55:0] m_tdata,   // [15:0] payload_length,
                                        // [47:16] source_address,
                                        // [55:48] protocol_number
    output      logic [2:0]  m_tuser    // [2:0] verdict
);

    logic                    byte_xfer;
    logic                    hdr_done;
    ipv4hc_pkg::hdr_fields_t hdr_fields;
    ipv4hc_pkg::result_t     result;
    ipv4hc_pkg::result_t     out_data;

    assign byte_xfer = s_tvalid && s_tready;

    ipv4hc_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .byte_valid      (byte_xfer),
        .header_byte     (s_tdata),
        .start_of_header (s_tuser[0]),
        .hdr_done        (hdr_done),
        .hdr_fields      (hdr_fields)
    );

    ipv4hc_classify u_classify (
        .hdr_fields (hdr_fields),
        .result     (result)
    );

    ipv4hc_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (hdr_done),
        .push_data  (result),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    assign m_tdata = {out_data.protocol_number, out_data.source_address,
                      out_data.payload_length};
    assign m_tuser = out_data.verdict;

endmodule

`default_nettype wire

// ===== bench/ipv4_header_checker_test.sv =====
// ----------------------------------------------------------------------------
// IPv4 header checker testbench
// Streams IPv4 headers byte by byte into ipv4_header_checker and predicts each
// verdict with a behavioral copy of the checker. Directed headers cover every
// verdict, check priority, length wrap, checksum carries, restarts and stray
// bytes. Random headers then run under several idle and stall mixes and
// several host addresses, including a long output hold.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_header_checker_test;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] header_byte
    logic [0:0]  s_tuser   = '0;   // [0] start_of_header
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;          // [15:0] payload_length, [47:16] source_address,
                                   // [55:48] protocol_number
    logic [2:0]  m_tuser;          // [2:0] verdict

    ipv4_header_checker u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #4 aclk = ~aclk;

    // Behavioral copy of the checker state.
    logic [4:0]  hdr_pos    = ipv4hc_pkg::HDR_BYTES;
    logic [19:0] word_sum   = '0;
    logic [7:0]  even_byte  = '0;
    logic [7:0]  ver_ihl_q  = '0;
    logic [15:0] tot_len_q  = '0;
    logic        frag_nz_q  = 1'b0;
    logic [15:0] rx_cksum_q = '0;
    logic [31:0] src_q      = '0;
    logic        dst_miss_q = 1'b0;
    logic [7:0]  proto_q    = '0;
    logic [31:0] host_addr  = '0;

    ipv4hc_pkg::result_t pending_verdicts [$];

    int errors         = 0;
    int bytes_taken    = 0;
    int results_seen   = 0;
    int settings_used  = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int sink_hold      = 0;

    logic [31:0] addr_setting = '0;
    logic [7:0]  frame_bytes [20];

    function automatic logic [15:0] fold_invert(input logic [19:0] s);
        logic [20:0] t;
        t = {1'b0, s};
        while (t[20:16] != 5'd0)
            t = {5'd0, t[15:0]} + {16'd0, t[20:16]};
        return ~t[15:0];
    endfunction

    task automatic absorb_header_byte(input logic [7:0] b, input logic sof);
        logic [15:0]         hw;
        logic [4:0]          pos;
        ipv4hc_pkg::result_t r;
        if (sof) begin
            hdr_pos    = 5'd0;
            word_sum   = '0;
            even_byte  = '0;
            dst_miss_q = 1'b0;
            frag_nz_q  = 1'b0;
            src_q      = '0;
        end
        if (hdr_pos < ipv4hc_pkg::HDR_BYTES) begin
            pos = hdr_pos;
            if (!pos[0]) begin
                even_byte = b;
            end else begin
                hw = {even_byte, b};
                if (pos == ipv4hc_pkg::POS_CKSUM_LO) rx_cksum_q = hw;
                else word_sum = word_sum + {4'd0, hw};
                if (pos == ipv4hc_pkg::POS_LEN_LO) tot_len_q = hw;
                if (pos == ipv4hc_pkg::POS_FRAG_LO)
                    frag_nz_q = (hw & ipv4hc_pkg::FRAG_MASK) != 16'd0;
            end
            if (pos == ipv4hc_pkg::POS_VER_IHL) ver_ihl_q = b;
            if (pos == ipv4hc_pkg::POS_PROTO) proto_q = b;
            if (pos >= ipv4hc_pkg::POS_SRC_FIRST && pos <= ipv4hc_pkg::POS_SRC_LAST)
                src_q = {src_q[23:0], b};
            if (pos >= ipv4hc_pkg::POS_DST_FIRST &&
                b != host_addr[8 * (ipv4hc_pkg::POS_LAST - pos) +: 8])
                dst_miss_q = 1'b1;
            hdr_pos = pos + 5'd1;
            if (hdr_pos == ipv4hc_pkg::HDR_BYTES) begin
                r.payload_length  = '0;
                r.source_address  = '0;
                r.protocol_number = proto_q;
                if ((ver_ihl_q & ipv4hc_pkg::VERSION_MASK) != ipv4hc_pkg::VERSION_IPV4)
                    r.verdict = ipv4hc_pkg::VERDICT_BAD_VERSION;
                else if ((ver_ihl_q & ipv4hc_pkg::IHL_MASK) != ipv4hc_pkg::IHL_NO_OPTS)
                    r.verdict = ipv4hc_pkg::VERDICT_OPTIONS;
                else if (frag_nz_q)
                    r.verdict = ipv4hc_pkg::VERDICT_FRAGMENT;
                else if (fold_invert(word_sum) != rx_cksum_q)
                    r.verdict = ipv4hc_pkg::VERDICT_BAD_CKSUM;
                else if (dst_miss_q)
                    r.verdict = ipv4hc_pkg::VERDICT_NOT_OURS;
                else begin
                    if (proto_q == ipv4hc_pkg::PROTO_ICMP)
                        r.verdict = ipv4hc_pkg::VERDICT_ICMP;
                    else if (proto_q == ipv4hc_pkg::PROTO_UDP)
                        r.verdict = ipv4hc_pkg::VERDICT_UDP;
                    else
                        r.verdict = ipv4hc_pkg::VERDICT_PROTO_UNRCH;
                    r.payload_length = tot_len_q - ipv4hc_pkg::PLEN_BIAS;
                    r.source_address = src_q;
                end
                pending_verdicts.push_back(r);
            end
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
            errors++;
        end
    endtask

    task automatic check_result;
        ipv4hc_pkg::result_t want;
        if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual verdict %0d tdata %h",
                     $time, m_tuser, m_tdata);
            errors++;
        end else begin
            want = pending_verdicts.pop_front();
            check_field("verdict", {29'd0, want.verdict}, {29'd0, m_tuser});
            check_field("payload_length", {16'd0, want.payload_length}, {16'd0, m_tdata[15:0]});
            check_field("source_address", want.source_address, m_tdata[47:16]);
            check_field("protocol_number", {24'd0, want.protocol_number},
                        {24'd0, m_tdata[55:48]});
            results_seen++;
        end
    endtask

    // Byte transfers feed the predictor before a same-edge register write takes effect.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                absorb_header_byte(s_tdata, s_tuser[0]);
                bytes_taken++;
            end
            if (cfg_we) host_addr = cfg_wdata;
            if (m_tvalid && m_tready) check_result();
        end
    end

    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= int'($urandom_range(99)) >= sink_stall_pct;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic sof);
        @(negedge aclk);
        while (int'($urandom_range(99)) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sof;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_frame(input int count);
        int i;
        for (i = 0; i < count; i++) send_byte(frame_bytes[i], i == 0);
    endtask

    task automatic send_strays(input int count);
        int i;
        for (i = 0; i < count; i++) send_byte(8'($urandom), 1'b0);
    endtask

    // Sender stays quiet until every result is in or a spin limit runs out, then lets
    // the block settle.
    task automatic wait_for_results;
        int spin;
        spin = 0;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0 && spin < 20000) begin
            @(negedge aclk);
            spin++;
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_host_address(input logic [31:0] a);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= a;
        @(negedge aclk);
        cfg_we <= 1'b0;
        addr_setting = a;
        settings_used++;
    endtask

    task automatic seal_checksum(input logic [15:0] flip);
        logic [19:0] s;
        int i;
        s = '0;
        for (i = 0; i < 20; i += 2)
            if (i != 10) s = s + {4'd0, frame_bytes[i], frame_bytes[i + 1]};
        {frame_bytes[10], frame_bytes[11]} = fold_invert(s) ^ flip;
    endtask

    task automatic build_header(input logic [7:0] vi, input logic [15:0] tlen,
                                input logic [15:0] frag, input logic [7:0] proto,
                                input logic [31:0] src, input logic [31:0] dst);
        frame_bytes[0]  = vi;
        frame_bytes[1]  = 8'($urandom);
        frame_bytes[2]  = tlen[15:8];
        frame_bytes[3]  = tlen[7:0];
        frame_bytes[4]  = 8'($urandom);
        frame_bytes[5]  = 8'($urandom);
        frame_bytes[6]  = frag[15:8];
        frame_bytes[7]  = frag[7:0];
        frame_bytes[8]  = 8'($urandom);
        frame_bytes[9]  = proto;
        frame_bytes[12] = src[31:24];
        frame_bytes[13] = src[23:16];
        frame_bytes[14] = src[15:8];
        frame_bytes[15] = src[7:0];
        frame_bytes[16] = dst[31:24];
        frame_bytes[17] = dst[23:16];
        frame_bytes[18] = dst[15:8];
        frame_bytes[19] = dst[7:0];
        seal_checksum(16'd0);
    endtask

    task automatic test_reset_state;
        // Nothing has started yet, so these bytes must be ignored.
        send_strays(3);
        build_header(8'h45, 16'd84, 16'h0000, ipv4hc_pkg::PROTO_ICMP, 32'h0A00_0001,
                     32'h0000_0000);
        send_frame(20);
    endtask

    task automatic test_each_verdict;
        logic [31:0] me;
        me = 32'hC0A8_0A02;
        set_host_address(me);
        build_header(8'h45, 16'd60, 16'h0000, ipv4hc_pkg::PROTO_ICMP, 32'h0A01_0203, me);
        send_frame(20);
        build_header(8'h45, 16'd28, 16'h4000, ipv4hc_pkg::PROTO_UDP, 32'hAC10_0005, me);
        send_frame(20);
        build_header(8'h45, 16'd40, 16'h0000, 8'd6, 32'h0102_0304, me);
        send_frame(20);
        build_header(8'h65, 16'd40, 16'h0000, ipv4hc_pkg::PROTO_ICMP, 32'h0102_0304, me);
        send_frame(20);
        build_header(8'h46, 16'd44, 16'h0000, ipv4hc_pkg::PROTO_UDP, 32'h0102_0304, me);
        send_frame(20);
        build_header(8'h45, 16'd40, 16'h2001, ipv4hc_pkg::PROTO_UDP, 32'h0102_0304, me);
        send_frame(20);
        build_header(8'h45, 16'd40, 16'h0000, ipv4hc_pkg::PROTO_ICMP, 32'h0102_0304, me);
        seal_checksum(16'h0100);
        send_frame(20);
        // Only the final destination byte differs.
        build_header(8'h45, 16'd40, 16'h0000, ipv4hc_pkg::PROTO_ICMP, 32'h0102_0304,
                     me ^ 32'h1);
        send_frame(20);
    endtask

    task automatic test_priority_and_extremes;
        logic [31:0] me;
        int i;
        me = addr_setting;
        build_header(8'h65, 16'd40, 16'h0010, ipv4hc_pkg::PROTO_ICMP, 32'h0102_0304,
                     me ^ 32'h8000_0000);
        seal_checksum(16'h1234);
        send_frame(20);
        build_header(8'h47, 16'd40, 16'h0001, ipv4hc_pkg::PROTO_UDP, 32'h0102_0304, me);
        send_frame(20);
        build_header(8'h45, 16'd40, 16'h1FFF, ipv4hc_pkg::PROTO_UDP, 32'h0102_0304, me);
        seal_checksum(16'hFFFF);
        send_frame(20);
        build_header(8'h45, 16'd40, 16'h0000, ipv4hc_pkg::PROTO_ICMP, 32'h0102_0304, ~me);
        seal_checksum(16'h0001);
        send_frame(20);
        // Total lengths below twenty wrap the payload length.
        build_header(8'h45, 16'd0, 16'h0000, ipv4hc_pkg::PROTO_ICMP, 32'hFFFF_FFFF, me);
        send_frame(20);
        build_header(8'h45, 16'hFFFF, 16'hE000, ipv4hc_pkg::PROTO_UDP, 32'h0000_0000, me);
        send_frame(20);
        build_header(8'h45, 16'd20, 16'h0000, 8'd0, 32'h8000_0001, me);
        send_frame(20);
        build_header(8'h45, 16'd19, 16'h0000, 8'd255, 32'h7FFF_FFFE, me);
        send_frame(20);
        for (i = 0; i < 20; i++) frame_bytes[i] = 8'h00;
        send_frame(20);
        for (i = 0; i < 20; i++) frame_bytes[i] = 8'hFF;
        send_frame(20);
    endtask

    task automatic test_restart_and_strays;
        logic [31:0] me;
        me = addr_setting;
        build_header(8'h45, 16'd100, 16'h0000, ipv4hc_pkg::PROTO_UDP, 32'h0B0B_0B0B, me);
        send_frame(9);
        build_header(8'h45, 16'd64, 16'h0000, ipv4hc_pkg::PROTO_ICMP, 32'h0C0C_0C0C, me);
        send_frame(19);
        // A start on what would have been the last byte abandons the header.
        build_header(8'h45, 16'd30, 16'h0000, ipv4hc_pkg::PROTO_UDP, 32'h0D0D_0D0D, me);
        send_frame(20);
        send_strays(5);
    endtask

    task automatic test_address_extremes;
        set_host_address(32'hFFFF_FFFF);
        // All-ones words force more than one carry out of the checksum fold.
        build_header(8'h45, 16'hFFFF, 16'hE000, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        frame_bytes[1] = 8'hFF;
        frame_bytes[4] = 8'hFF;
        frame_bytes[5] = 8'hFF;
        frame_bytes[8] = 8'hFF;
        seal_checksum(16'd0);
        send_frame(20);
        build_header(8'h45, 16'd48, 16'h0000, ipv4hc_pkg::PROTO_UDP, 32'h0102_0304,
                     32'hFFFF_FFFE);
        send_frame(20);
        set_host_address(32'h0000_0000);
        build_header(8'h45, 16'd48, 16'h0000, ipv4hc_pkg::PROTO_UDP, 32'h0102_0304,
                     32'h0000_0000);
        send_frame(20);
    endtask

    task automatic random_header;
        int kind;
        int i;
        logic [7:0]  vi;
        logic [15:0] tl;
        logic [15:0] frag;
        logic [7:0]  pr;
        logic [31:0] dst;
        logic [15:0] flip;
        kind = $urandom_range(99);
        vi   = 8'h45;
        tl   = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1500, 20));
        frag = {3'($urandom), 13'd0};
        case ($urandom_range(2))
            0: pr = ipv4hc_pkg::PROTO_ICMP;
            1: pr = ipv4hc_pkg::PROTO_UDP;
            default: pr = 8'($urandom);
        endcase
        dst  = addr_setting;
        flip = 16'd0;
        if (kind >= 70) begin
            if ($urandom_range(99) < 40) vi[7:4] = 4'(($urandom_range(14) + 5) % 16);
            if ($urandom_range(99) < 40) vi[3:0] = 4'(($urandom_range(14) + 6) % 16);
            if ($urandom_range(99) < 40) frag[12:0] = 13'($urandom_range(8191, 1));
            if ($urandom_range(99) < 40) flip = 16'($urandom_range(65535, 1));
            if ($urandom_range(99) < 40) dst = dst ^ (32'd1 << $urandom_range(31));
        end
        build_header(vi, tl, frag, pr, $urandom, dst);
        if (flip != 16'd0) seal_checksum(flip);
        if (kind >= 94)
            for (i = 0; i < 20; i++) frame_bytes[i] = 8'($urandom);
    endtask

    task automatic run_random_headers(input int count);
        int n;
        int roll;
        for (n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                send_strays($urandom_range(3, 1));
            end else if (roll < 18) begin
                random_header();
                send_frame($urandom_range(19, 1));
            end
            random_header();
            send_frame(20);
        end
    endtask

    task automatic test_random_phases;
        set_host_address($urandom);
        src_idle_pct = 0;  sink_stall_pct = 0;
        run_random_headers(2);
        set_host_address(32'hFFFF_FFFF);
        src_idle_pct = 60; sink_stall_pct = 0;
        run_random_headers(2);
        set_host_address($urandom);
        src_idle_pct = 0;  sink_stall_pct = 60;
        run_random_headers(2);
        set_host_address(32'h0000_0000);
        src_idle_pct = 36; sink_stall_pct = 36;
        run_random_headers(2);
    endtask

    // The output is held off long enough for the block to fill and stall the input.
    task automatic test_output_hold;
        set_host_address($urandom);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        @(posedge aclk);
        sink_hold = 400;
        run_random_headers(3);
        wait_for_results();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_each_verdict();
        test_priority_and_extremes();
        test_restart_and_strays();
        test_address_extremes();
        test_output_hold();
        test_random_phases();
        wait_for_results();
        if (pending_verdicts.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_verdicts.size());
            errors += pending_verdicts.size();
        end
        $display("Checked %0d verdicts from %0d header byte transfers under %0d address writes,",
                 results_seen, bytes_taken, settings_used);
        $display("with every verdict, restarts, stray bytes, idle and stall mixes, and a long hold.");
        if (errors == 0) begin
            $display("ipv4_header_checker regression: pass");
        end else begin
            $display("ipv4_header_checker regression: fail");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("%0t: run timed out", $time);
        $display("ipv4_header_checker regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
